// ===== sv/ddo_pkg.sv =====
`default_nettype none

package ddo_pkg;

    // Fixed widths of the datapath.
    localparam int XW = 36;    // CORDIC vector components, Q.28
    localparam int AW = 34;    // CORDIC residual angle, Q3.29
    localparam int RW = 40;    // angle reduction register, Q3.29
    localparam int KW = 30;    // inverse CORDIC gain, Q30

    // Angle constants in Q3.29.
    localparam logic signed [RW-1:0] PI_Q      = 40'sd1686629713;
    localparam logic signed [RW-1:0] TWO_PI_Q  = 40'sd3373259426;
    localparam logic signed [RW-1:0] HALF_PI_Q = 40'sd843314857;

    // Angle reduction runs shifts 6 down to 0 and then 0 once more.
    localparam logic [2:0] WRAP_CNT_INIT = 3'd7;

    // Configuration register reset values.
    localparam logic [15:0] RST_RADIUS    = 16'd3277;
    localparam logic [15:0] RST_INV_TRACK = 16'd10240;

    typedef enum logic [1:0] {
        REG_LEFT_RADIUS  = 2'd0,
        REG_RIGHT_RADIUS = 2'd1,
        REG_INV_TRACK    = 2'd2
    } cfg_index_t;

    // Arctangent of 2^-i in Q3.29.
    function automatic logic signed [AW-1:0] atan_q(input logic [4:0] i);
        logic signed [AW-1:0] v;
        case (i)
            5'd0:    v = 34'sd421657428;
            5'd1:    v = 34'sd248918915;
            5'd2:    v = 34'sd131521918;
            5'd3:    v = 34'sd66762579;
            5'd4:    v = 34'sd33510843;
            5'd5:    v = 34'sd16771758;
            5'd6:    v = 34'sd8387925;
            5'd7:    v = 34'sd4194219;
            5'd8:    v = 34'sd2097141;
            5'd9:    v = 34'sd1048575;
            5'd30:   v = '0;
            5'd31:   v = '0;
            default: v = 34'sd1 << (5'd29 - i);
        endcase
        return v;
    endfunction

    // Inverse CORDIC gain in Q30, evaluated at elaboration. K^2 is built as a
    // truncating product in Q32 by long division, then K is its floor root.
    function automatic logic [KW-1:0] cordic_gain(input int steps);
        logic [63:0] k2;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] d;
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        k2 = 64'd1 << 32;
        for (int i = 0; i < 16; i++) begin
            if (i < steps) begin
                d   = (64'd1 << (2 * i)) + 64'd1;
                q   = '0;
                rem = '0;
                for (int j = 63; j >= 0; j--) begin
                    rem = {rem[62:0], k2[j]};
                    if (rem >= d) begin
                        rem  = rem - d;
                        q[j] = 1'b1;
                    end
                end
                k2 = k2 - q;
            end
        end
        n    = k2 << 28;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[KW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/diff_drive_odometry.sv =====
// The sequencer holds one item at a time and takes a new input transfer only once it is idle;
// it steps the item through the shared multiplier, the shared angle reduction adder and the
// CORDIC iterations in turn.
// A waiting result does not block the next input transfer; it only stalls the final update.
// Reset (rst_n, asynchronous, active low) clears the pose to zero, empties the output and
// loads the wheel radii with 3277 and the track reciprocal with 10240.
`default_nettype none

module diff_drive_odometry
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] left_delta,
    input  wire logic signed [15:0] right_delta,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [31:0]      heading
);

    localparam logic [KW-1:0] GAIN = cordic_gain(CORDIC_STEPS);

    // Sequencer. The first product is taken in the cycle of the input transfer,
    // then the remaining three products share the same multiplier, the midpoint
    // angle is reduced into [-pi, pi), the CORDIC rotates, and the heading is
    // reduced again on the same reduction adder before the pose is committed.
    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_MR   = 11'b000_0000_0010,
        ST_SD   = 11'b000_0000_0100,
        ST_MT   = 11'b000_0000_1000,
        ST_MK   = 11'b000_0001_0000,
        ST_WA   = 11'b000_0010_0000,
        ST_FOLD = 11'b000_0100_0000,
        ST_ROT  = 11'b000_1000_0000,
        ST_HSET = 11'b001_0000_0000,
        ST_WH   = 11'b010_0000_0000,
        ST_DONE = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0] rl_reg;
    logic [15:0] rr_reg;
    logic [15:0] inv_reg;

    // Datapath registers.
    logic signed [15:0]   dr_reg, dr_next;
    logic signed [31:0]   pl_reg, pl_next;
    logic signed [32:0]   sum_reg, sum_next;
    logic signed [32:0]   diff_reg, diff_next;
    logic signed [63:0]   mul_reg, mul_next;
    logic signed [RW-1:0] dphi_reg, dphi_next;
    logic signed [RW-1:0] r_reg, r_next;
    logic [2:0]           wcnt_reg, wcnt_next;

    // Pose state, which also serves as the output register.
    logic signed [31:0] x_acc_reg, x_acc_next;
    logic signed [31:0] y_acc_reg, y_acc_next;
    logic signed [31:0] phi_acc_reg, phi_acc_next;
    logic               out_valid_reg, out_valid_next;

    // Shared multiplier.
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [65:0] mul_full;

    // Shared angle reduction step.
    logic [2:0]           wrap_sh;
    logic signed [RW-1:0] wrap_m;
    logic signed [RW-1:0] wrap_r;

    // Intermediate values.
    logic signed [31:0]   pr_w;
    logic signed [63:0]   dphi_full;
    logic signed [63:0]   half_full;
    logic signed [RW-1:0] half_w;
    logic signed [63:0]   x0_full;
    logic signed [XW-1:0] x0_w;
    logic signed [RW-1:0] ang;
    logic signed [XW-1:0] xr_w;
    logic signed [XW-1:0] yr_w;
    logic signed [RW-1:0] phn;

    // CORDIC interface.
    logic                 cdc_start;
    logic signed [XW-1:0] cdc_x0;
    logic signed [AW-1:0] cdc_a0;
    logic                 cdc_busy;
    logic signed [XW-1:0] cdc_x;
    logic signed [XW-1:0] cdc_y;

    logic in_xfer;
    logic out_free;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] s;
        if (v > 34'sd2147483647) begin
            s = 32'sh7fff_ffff;
        end else if (v < -34'sd2147483648) begin
            s = 32'sh8000_0000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

    assign in_xfer  = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mul_a = 34'(left_delta);
                mul_b = signed'({16'd0, rl_reg});
            end
            ST_MR:
            begin
                mul_a = 34'(dr_reg);
                mul_b = signed'({16'd0, rr_reg});
            end
            ST_MT:
            begin
                mul_a = 34'(diff_reg);
                mul_b = signed'({16'd0, inv_reg});
            end
            ST_MK:
            begin
                mul_a = 34'(sum_reg);
                mul_b = signed'({2'd0, GAIN});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // One restoring step of the modulo 2*pi reduction. The value is kept
    // offset by pi so that the reduced result lies in [0, 2*pi).
    always_comb
    begin
        wrap_sh = (wcnt_reg == 3'd0) ? 3'd0 : wcnt_reg - 3'd1;
        wrap_m  = TWO_PI_Q <<< wrap_sh;
        if (r_reg >= wrap_m) begin
            wrap_r = r_reg - wrap_m;
        end else if (r_reg < 0) begin
            wrap_r = r_reg + wrap_m;
        end else begin
            wrap_r = r_reg;
        end
    end

    // Rounding and folding arithmetic, all round to nearest with ties upward.
    always_comb
    begin
        pr_w      = mul_reg[31:0];
        dphi_full = (mul_reg + 64'sd1024) >>> 11;
        half_full = (mul_reg + 64'sd2048) >>> 12;
        half_w    = half_full[RW-1:0];
        x0_full   = (mul_reg + 64'sd1073741824) >>> 31;
        x0_w      = x0_full[XW-1:0];
        ang       = r_reg - PI_Q;
        xr_w      = (cdc_x + 36'sd2048) >>> 12;
        yr_w      = (cdc_y + 36'sd2048) >>> 12;
        phn       = r_reg - PI_Q;

        // An angle outside the right half plane is turned by pi and the
        // vector negated, which keeps the CORDIC inside its convergence range.
        if (ang > HALF_PI_Q) begin
            cdc_a0 = AW'(ang - PI_Q);
            cdc_x0 = -x0_w;
        end else if (ang < -HALF_PI_Q) begin
            cdc_a0 = AW'(ang + PI_Q);
            cdc_x0 = -x0_w;
        end else begin
            cdc_a0 = AW'(ang);
            cdc_x0 = x0_w;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        dr_next        = dr_reg;
        pl_next        = pl_reg;
        sum_next       = sum_reg;
        diff_next      = diff_reg;
        mul_next       = mul_reg;
        dphi_next      = dphi_reg;
        r_next         = r_reg;
        wcnt_next      = wcnt_reg;
        x_acc_next     = x_acc_reg;
        y_acc_next     = y_acc_reg;
        phi_acc_next   = phi_acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        cdc_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                // Left product rL*dL is formed in the transfer cycle.
                mul_next = mul_full[63:0];
                if (in_xfer) begin
                    dr_next    = right_delta;
                    state_next = ST_MR;
                end
            end
            ST_MR:
            begin
                pl_next    = mul_reg[31:0];
                mul_next   = mul_full[63:0];
                state_next = ST_SD;
            end
            ST_SD:
            begin
                sum_next   = 33'(pl_reg) + 33'(pr_w);
                diff_next  = 33'(pr_w) - 33'(pl_reg);
                state_next = ST_MT;
            end
            ST_MT:
            begin
                mul_next   = mul_full[63:0];
                state_next = ST_MK;
            end
            ST_MK:
            begin
                // The product holds dphi in Q8.40; both dphi and its half are
                // rounded from it before the multiplier is reused for ds*K.
                dphi_next  = dphi_full[RW-1:0];
                r_next     = RW'(phi_acc_reg) + half_w + PI_Q;
                mul_next   = mul_full[63:0];
                wcnt_next  = WRAP_CNT_INIT;
                state_next = ST_WA;
            end
            ST_WA:
            begin
                r_next = wrap_r;
                if (wcnt_reg == 3'd0) begin
                    state_next = ST_FOLD;
                end else begin
                    wcnt_next = wcnt_reg - 3'd1;
                end
            end
            ST_FOLD:
            begin
                cdc_start  = 1'b1;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                if (!cdc_busy) begin
                    state_next = ST_HSET;
                end
            end
            ST_HSET:
            begin
                r_next     = RW'(phi_acc_reg) + dphi_reg + PI_Q;
                wcnt_next  = WRAP_CNT_INIT;
                state_next = ST_WH;
            end
            ST_WH:
            begin
                r_next = wrap_r;
                if (wcnt_reg == 3'd0) begin
                    state_next = ST_DONE;
                end else begin
                    wcnt_next = wcnt_reg - 3'd1;
                end
            end
            ST_DONE:
            begin
                // The pose only changes once the previous result has left.
                if (out_free) begin
                    x_acc_next     = sat32(34'(x_acc_reg) + 34'(xr_w));
                    y_acc_next     = sat32(34'(y_acc_reg) + 34'(yr_w));
                    phi_acc_next   = phn[31:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            wcnt_reg      <= '0;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            phi_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wcnt_reg      <= wcnt_next;
            x_acc_reg     <= x_acc_next;
            y_acc_reg     <= y_acc_next;
            phi_acc_reg   <= phi_acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg   <= dr_next;
        pl_reg   <= pl_next;
        sum_reg  <= sum_next;
        diff_reg <= diff_next;
        mul_reg  <= mul_next;
        dphi_reg <= dphi_next;
        r_reg    <= r_next;
    end

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rl_reg  <= RST_RADIUS;
            rr_reg  <= RST_RADIUS;
            inv_reg <= RST_INV_TRACK;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LEFT_RADIUS:  rl_reg  <= cfg_data;
                REG_RIGHT_RADIUS: rr_reg  <= cfg_data;
                REG_INV_TRACK:    inv_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cdc_start),
        .x0    (cdc_x0),
        .a0    (cdc_a0),
        .busy  (cdc_busy),
        .x     (cdc_x),
        .y     (cdc_y)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign pos_x     = x_acc_reg;
    assign pos_y     = y_acc_reg;
    assign heading   = phi_acc_reg;

endmodule

`default_nettype wire

// ===== sv/ddo_cordic.sv =====
`default_nettype none

module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [XW-1:0] x0,
    input  wire logic signed [AW-1:0] a0,
    output logic                      busy,
    output logic signed [XW-1:0]      x,
    output logic signed [XW-1:0]      y
);

    localparam int ITW = $clog2(STEPS);
    localparam logic [ITW-1:0] LAST = ITW'(STEPS - 1);

    logic                 busy_reg, busy_next;
    logic [ITW-1:0]       it_reg, it_next;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [AW-1:0] a_reg, a_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [AW-1:0] at;

    // One micro-rotation per cycle through a single add/subtract pair.
    always_comb
    begin
        xs        = x_reg >>> it_reg;
        ys        = y_reg >>> it_reg;
        at        = atan_q(5'(it_reg));
        busy_next = busy_reg;
        it_next   = it_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        a_next    = a_reg;
        if (start) begin
            busy_next = 1'b1;
            it_next   = '0;
            x_next    = x0;
            y_next    = '0;
            a_next    = a0;
        end else if (busy_reg) begin
            if (a_reg >= 0) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                a_next = a_reg - at;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                a_next = a_reg + at;
            end
            if (it_reg == LAST) begin
                busy_next = 1'b0;
            end else begin
                it_next = it_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            it_reg   <= '0;
        end else begin
            busy_reg <= busy_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        a_reg <= a_next;
    end

    assign busy = busy_reg;
    assign x    = x_reg;
    assign y    = y_reg;

endmodule

`default_nettype wire
